FILE: src/xoodoo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Xoodoo permutation block.
// No dependencies; used by xoodoo_round_cell and xoodoo_permutation_top.
package xoodoo_pkg;

  localparam int unsigned LaneWidth = 32;
  localparam int unsigned NumLanes  = 12;
  localparam int unsigned NumSheets = 4;
  localparam int unsigned MaxRounds = 12;

  typedef logic [LaneWidth-1:0] lane_t;
  typedef lane_t [NumLanes-1:0] state_t;

  typedef struct packed {
    lane_t in_lane_11;
    lane_t in_lane_10;
    lane_t in_lane_9;
    lane_t in_lane_8;
    lane_t in_lane_7;
    lane_t in_lane_6;
    lane_t in_lane_5;
    lane_t in_lane_4;
    lane_t in_lane_3;
    lane_t in_lane_2;
    lane_t in_lane_1;
    lane_t in_lane_0;
  } xoodoo_in_t;

  typedef struct packed {
    lane_t out_lane_11;
    lane_t out_lane_10;
    lane_t out_lane_9;
    lane_t out_lane_8;
    lane_t out_lane_7;
    lane_t out_lane_6;
    lane_t out_lane_5;
    lane_t out_lane_4;
    lane_t out_lane_3;
    lane_t out_lane_2;
    lane_t out_lane_1;
    lane_t out_lane_0;
  } xoodoo_out_t;

  localparam lane_t RoundConsts [MaxRounds] = '{
    32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
    32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
    32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
  };

  localparam int unsigned ThetaRotA = 5;
  localparam int unsigned ThetaRotB = 14;
  localparam int unsigned WestRot   = 11;
  localparam int unsigned EastRot1  = 1;
  localparam int unsigned EastRot2  = 8;

  function automatic lane_t rotl(input lane_t v, input int unsigned r);
    return (v << r) | (v >> (LaneWidth - r));
  endfunction

endpackage

FILE: src/xoodoo_round_cell.sv
`timescale 1ns / 1ps
// One Xoodoo round as a registered pipeline cell with a valid/ready handshake.
// Depends on xoodoo_pkg.
module xoodoo_round_cell #(
  parameter logic [31:0] RC_VALUE = 32'h0000_0012
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  xoodoo_pkg::state_t state_i,
  output logic              valid_o,
  input  logic              ready_i,
  output xoodoo_pkg::state_t state_o
);

  xoodoo_pkg::lane_t  par [xoodoo_pkg::NumSheets];
  xoodoo_pkg::lane_t  eff [xoodoo_pkg::NumSheets];
  xoodoo_pkg::state_t theta_s;
  xoodoo_pkg::state_t west_s;
  xoodoo_pkg::state_t chi_s;
  xoodoo_pkg::state_t state_d;
  xoodoo_pkg::state_t state_q;
  logic               valid_q;

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      par[x] = state_i[x] ^ state_i[x+4] ^ state_i[x+8];
    end
    for (int x = 0; x < 4; x++) begin
      eff[x] = xoodoo_pkg::rotl(par[(x+3)%4], xoodoo_pkg::ThetaRotA) ^
               xoodoo_pkg::rotl(par[(x+3)%4], xoodoo_pkg::ThetaRotB);
    end
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 3; y++) begin
        theta_s[x+4*y] = state_i[x+4*y] ^ eff[x];
      end
    end
    for (int x = 0; x < 4; x++) begin
      west_s[x]   = theta_s[x];
      west_s[x+4] = theta_s[((x+3)%4)+4];
      west_s[x+8] = xoodoo_pkg::rotl(theta_s[x+8], xoodoo_pkg::WestRot);
    end
    west_s[0] = west_s[0] ^ RC_VALUE;
    for (int x = 0; x < 4; x++) begin
      for (int y = 0; y < 3; y++) begin
        chi_s[x+4*y] = west_s[x+4*y] ^
                       (~west_s[x+4*((y+1)%3)] & west_s[x+4*((y+2)%3)]);
      end
    end
    for (int x = 0; x < 4; x++) begin
      state_d[x]   = chi_s[x];
      state_d[x+4] = xoodoo_pkg::rotl(chi_s[x+4], xoodoo_pkg::EastRot1);
      state_d[x+8] = xoodoo_pkg::rotl(chi_s[((x+2)%4)+8], xoodoo_pkg::EastRot2);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

FILE: src/xoodoo_permutation_top.sv
`timescale 1ns / 1ps
// Top level of the Xoodoo permutation: a chain of registered round cells.
// Depends on xoodoo_pkg and xoodoo_round_cell.

// The block applies the last ROUND_COUNT rounds of Xoodoo to a 384-bit state given as
// twelve 32-bit lanes. Each round is one registered cell in a chain, and a new transaction can
// enter every cycle unless the chain is stalled by backpressure on the output.
// Each cell holds its state while the cell after it is full and stalled, so backpressure
// on the output fills the chain before in_ready_o drops.
module xoodoo_permutation_top #(
  parameter int unsigned ROUND_COUNT = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  xoodoo_pkg::xoodoo_in_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output xoodoo_pkg::xoodoo_out_t out_data_o
);

  localparam int unsigned FirstRound = xoodoo_pkg::MaxRounds - ROUND_COUNT;

  xoodoo_pkg::state_t            stage_state [ROUND_COUNT+1];
  logic [ROUND_COUNT:0]          stage_valid;
  logic [ROUND_COUNT:0]          stage_ready;
  logic [ROUND_COUNT-1:0]        cell_valid;

  assign stage_state[0] = xoodoo_pkg::state_t'(in_data_i);
  assign stage_valid[0] = in_valid_i;
  assign in_ready_o     = stage_ready[0];

  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_cell
    xoodoo_round_cell #(
      .RC_VALUE(xoodoo_pkg::RoundConsts[FirstRound + k])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(stage_valid[k]),
      .ready_o(stage_ready[k]),
      .state_i(stage_state[k]),
      .valid_o(stage_valid[k+1]),
      .ready_i(stage_ready[k+1]),
      .state_o(stage_state[k+1])
    );
  end

  assign stage_ready[ROUND_COUNT] = out_ready_i;
  assign out_valid_o = stage_valid[ROUND_COUNT];
  assign out_data_o  = xoodoo_pkg::xoodoo_out_t'(stage_state[ROUND_COUNT]);
  assign cell_valid  = stage_valid[ROUND_COUNT:1];

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&cell_valid) && !out_ready_i)
    else $error("input stalled while the round chain has room");

  a_fill_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !(out_valid_o && out_ready_i))
    |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
    else $error("accepted transaction was not kept in the round chain");

  a_drain_on_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && in_ready_o) && out_valid_o && out_ready_i)
    |=> $countones(cell_valid) + 1 == $past($countones(cell_valid)))
    else $error("delivered transaction was not removed from the round chain");

endmodule
